// ----- src/led_effect_brightness_core_defines.svh -----
// ----------------------------------------------------------------------------
// led_effect_brightness_core_defines
// assertion macros shared by the brightness core rtl
// ----------------------------------------------------------------------------
`ifndef LED_EFFECT_BRIGHTNESS_CORE_DEFINES_SVH
`define LED_EFFECT_BRIGHTNESS_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LEB_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define LEB_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/leb_pkg.sv -----
// ----------------------------------------------------------------------------
// leb_pkg
// shared types, constants and the sine rom contents of the brightness core
// ----------------------------------------------------------------------------
`default_nettype none

package leb_pkg;

   // field and datapath widths
   localparam int T_W        = 32;
   localparam int S_W        = 7;
   localparam int P_W        = 4;
   localparam int D_W        = 12;
   localparam int R_W        = T_W + 1;
   localparam int DVD_W      = T_W + 1;
   localparam int CNT_W      = $clog2(DVD_W + 1);
   localparam int CSR_IDX_W  = 2;
   localparam int B_W        = 8;

   // sine rom geometry
   localparam int SINE_ENTRIES = 256;
   localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
   localparam int Q_W          = (SINE_IDX_W > B_W) ? SINE_IDX_W : B_W;
   localparam int X_W          = D_W + 1 + Q_W;

   // pattern timing constants
   localparam logic [D_W-1:0] BASE_BREATH  = D_W'(2000);
   localparam logic [D_W-1:0] BASE_FAST    = D_W'(100);
   localparam logic [D_W-1:0] BASE_SLOW    = D_W'(500);
   localparam logic [D_W-1:0] BASE_HEART   = D_W'(1000);
   localparam logic [D_W-1:0] BASE_WAVE    = D_W'(1500);
   localparam logic [D_W-1:0] BASE_COMET   = D_W'(3000);
   localparam logic [D_W-1:0] BASE_PULSE   = D_W'(200);
   localparam logic [S_W-1:0] SPEED_MAX    = S_W'(100);
   localparam logic [D_W-1:0] FAST_ON      = D_W'(50);
   localparam logic [D_W-1:0] SLOW_ON      = D_W'(250);
   localparam logic [D_W-1:0] HEART_1      = D_W'(100);
   localparam logic [D_W-1:0] HEART_2      = D_W'(200);
   localparam logic [D_W-1:0] HEART_3      = D_W'(300);
   localparam logic [D_W-1:0] HEART_4      = D_W'(400);
   localparam logic [B_W-1:0] BRIGHT_MAX   = 8'd255;
   localparam logic [B_W-1:0] BRIGHT_DIM   = 8'd50;
   localparam logic [B_W-1:0] BRIGHT_HALF  = 8'd128;
   localparam logic [B_W-1:0] COMET_HEAD   = 8'd200;
   localparam logic [B_W-1:0] COMET_TAIL   = 8'd150;
   localparam logic [2:0]     COMET_GAIN   = 3'd5;
   localparam logic [B_W-1:0] TWINKLE_HI   = 8'd200;
   localparam logic [B_W-1:0] TWINKLE_LO   = 8'd100;
   localparam logic [T_W-1:0] TWINKLE_LED  = 32'd1000;
   localparam logic [T_W-1:0] LCG_MUL      = 32'd1103515245;
   localparam logic [T_W-1:0] LCG_INC      = 32'd12345;
   localparam logic [DVD_W-1:0] RECIP_NUM  = {1'b1, {T_W{1'b0}}};

   // pattern codes
   typedef enum logic [P_W-1:0] {
      PAT_OFF     = 4'd0,
      PAT_BREATH  = 4'd1,
      PAT_FAST    = 4'd2,
      PAT_SLOW    = 4'd3,
      PAT_HEART   = 4'd4,
      PAT_WAVE    = 4'd5,
      PAT_COMET   = 4'd6,
      PAT_PULSE   = 4'd7,
      PAT_TWINKLE = 4'd8
   } pattern_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE  = 2'd0,
      CSR_PATTERN = 2'd1,
      CSR_SPEED   = 2'd2
   } csr_index_type;

   // period constant sequencer states
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_BASE,
      SEQ_RECIP1,
      SEQ_RECIP2
   } seq_state_type;

   // divider handshake
   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [D_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

   // settings seen by the datapath
   typedef struct packed {
      logic           active;
      logic [P_W-1:0] pattern;
      logic [D_W-1:0] d1;
      logic [R_W-1:0] r1;
      logic [D_W-1:0] d2;
      logic [R_W-1:0] r2;
   } cfg_type;

   // sine rom built at elaboration, q30 series on the first quadrant
   localparam logic [63:0] FX_ONE     = 64'd1 << 30;
   localparam logic [63:0] FX_HALF_PI = 64'd1686629713;

   typedef logic [SINE_ENTRIES-1:0][B_W-1:0] sine_table_type;

   function automatic logic [63:0] fx_step(input logic [63:0] term,
                                           input logic [63:0] x2);
      logic [63:0] p;
      p = (term * x2) >> 30;
      return p;
   endfunction

   function automatic logic [63:0] quarter_sine(input logic [63:0] r);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x    = (r * FX_HALF_PI + SINE_ENTRIES / 2) / SINE_ENTRIES;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = fx_step(term, x2) / 6;
      sum  = (sum > term) ? sum - term : 64'd0;
      term = fx_step(term, x2) / 20;
      sum  = sum + term;
      term = fx_step(term, x2) / 42;
      sum  = (sum > term) ? sum - term : 64'd0;
      term = fx_step(term, x2) / 72;
      sum  = sum + term;
      term = fx_step(term, x2) / 110;
      sum  = (sum > term) ? sum - term : 64'd0;
      term = fx_step(term, x2) / 156;
      sum  = sum + term;
      term = fx_step(term, x2) / 210;
      sum  = (sum > term) ? sum - term : 64'd0;
      term = fx_step(term, x2) / 272;
      sum  = sum + term;
      term = fx_step(term, x2) / 342;
      sum  = (sum > term) ? sum - term : 64'd0;
      term = fx_step(term, x2) / 420;
      sum  = sum + term;
      return (sum > FX_ONE) ? FX_ONE : sum;
   endfunction

   function automatic sine_table_type build_sine();
      sine_table_type tab;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] r;
      logic [63:0] mag;
      logic [63:0] v;
      for (int i = 0; i < SINE_ENTRIES; i++) begin
         q   = (64'(4 * i)) / SINE_ENTRIES;
         rem = 64'(4 * i) - q * SINE_ENTRIES;
         r   = q[0] ? 64'(SINE_ENTRIES) - rem : rem;
         if (r == 64'd0) begin
            mag = 64'd0;
         end else if (r >= 64'(SINE_ENTRIES)) begin
            mag = FX_ONE;
         end else begin
            mag = quarter_sine(r);
         end
         v = (q >= 64'd2) ? FX_ONE - mag : FX_ONE + mag;
         tab[i] = B_W'((v * 64'd255) >> 31);
      end
      return tab;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine();

endpackage

`default_nettype wire

// ----- src/leb_div.sv -----
// ----------------------------------------------------------------------------
// leb_div
// restoring divider, one quotient bit per cycle, for the period constants
// ----------------------------------------------------------------------------
`default_nettype none

module leb_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire leb_pkg::div_req_type div_req,
   output leb_pkg::div_rsp_type      div_rsp
);

   localparam int DVD_W = leb_pkg::DVD_W;
   localparam int D_W   = leb_pkg::D_W;
   localparam int CNT_W = leb_pkg::CNT_W;

   logic [DVD_W-1:0] dvd_ff;
   logic [D_W-1:0]   rem_ff;
   logic [D_W-1:0]   dsr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             done_ff;
   logic [D_W:0]     trial;
   logic [D_W:0]     diff;
   logic             ge;
   logic [D_W-1:0]   rem_in;

   // trial subtraction of the next dividend bit
   always_comb begin
      trial  = {rem_ff, dvd_ff[DVD_W-1]};
      ge     = trial >= {1'b0, dsr_ff};
      diff   = trial - {1'b0, dsr_ff};
      rem_in = ge ? diff[D_W-1:0] : trial[D_W-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(DVD_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // dividend shifts out while quotient bits shift in
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         dvd_ff <= div_req.dividend;
         dsr_ff <= div_req.divisor;
         rem_ff <= '0;
      end else if (run_ff) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

`default_nettype wire

// ----- src/leb_cfg.sv -----
// ----------------------------------------------------------------------------
// leb_cfg
// settings registers and the sequencer that derives period and reciprocal
// ----------------------------------------------------------------------------
`default_nettype none

module leb_cfg (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [leb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [leb_pkg::S_W-1:0]            csr_data,
   output logic                                    busy,
   output leb_pkg::cfg_type                        cfg,
   output leb_pkg::div_req_type                    div_req,
   input  wire leb_pkg::div_rsp_type               div_rsp
);

   localparam int D_W = leb_pkg::D_W;
   localparam int R_W = leb_pkg::R_W;
   localparam int S_W = leb_pkg::S_W;
   localparam int P_W = leb_pkg::P_W;

   logic                   active_ff;
   logic [P_W-1:0]         pattern_ff;
   logic [S_W-1:0]         speed_ff;
   logic                   restart_ff;
   logic                   restart_in;
   leb_pkg::seq_state_type state_ff;
   leb_pkg::seq_state_type state_in;
   logic [D_W-1:0]         d1_ff, d1_in;
   logic [D_W-1:0]         d2_ff, d2_in;
   logic [R_W-1:0]         r1_ff;
   logic [R_W-1:0]         r2_ff;
   logic [S_W-1:0]         speed_lim;
   logic [D_W-1:0]         base;
   logic                   use_speed;
   logic                   csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid;

   // speed limited to its legal range
   always_comb begin
      if (speed_ff == '0) begin
         speed_lim = S_W'(1);
      end else if (speed_ff > leb_pkg::SPEED_MAX) begin
         speed_lim = leb_pkg::SPEED_MAX;
      end else begin
         speed_lim = speed_ff;
      end
   end

   // base period for the pattern
   always_comb begin
      use_speed = 1'b1;
      unique case (pattern_ff)
         leb_pkg::PAT_BREATH:  base = leb_pkg::BASE_BREATH;
         leb_pkg::PAT_FAST:    base = leb_pkg::BASE_FAST;
         leb_pkg::PAT_SLOW:    base = leb_pkg::BASE_SLOW;
         leb_pkg::PAT_WAVE:    base = leb_pkg::BASE_WAVE;
         leb_pkg::PAT_COMET:   base = leb_pkg::BASE_COMET;
         leb_pkg::PAT_PULSE:   base = leb_pkg::BASE_PULSE;
         leb_pkg::PAT_TWINKLE: base = leb_pkg::BASE_PULSE;
         default: begin
            base      = leb_pkg::BASE_HEART;
            use_speed = 1'b0;
         end
      endcase
   end

   // divisors taken from the period result
   always_comb begin
      d1_in = d1_ff;
      d2_in = d2_ff;
      if (state_ff == leb_pkg::SEQ_BASE && div_rsp.done && !restart_ff) begin
         d2_in = div_rsp.quotient[D_W-1:0];
         if (pattern_ff == leb_pkg::PAT_PULSE) begin
            d1_in = {div_rsp.quotient[D_W-3:0], 2'b00};
         end else begin
            d1_in = div_rsp.quotient[D_W-1:0];
         end
      end
   end

   // sequencer: period, then reciprocals of both divisors
   always_comb begin
      state_in = state_ff;
      div_req.start = 1'b0;
      if (restart_ff) begin
         state_in      = leb_pkg::SEQ_BASE;
         div_req.start = 1'b1;
      end else begin
         unique case (state_ff)
            leb_pkg::SEQ_BASE: begin
               if (div_rsp.done) begin
                  state_in      = leb_pkg::SEQ_RECIP1;
                  div_req.start = 1'b1;
               end
            end
            leb_pkg::SEQ_RECIP1: begin
               if (div_rsp.done) begin
                  state_in      = leb_pkg::SEQ_RECIP2;
                  div_req.start = 1'b1;
               end
            end
            leb_pkg::SEQ_RECIP2: begin
               if (div_rsp.done) begin
                  state_in = leb_pkg::SEQ_IDLE;
               end
            end
            default: state_in = leb_pkg::SEQ_IDLE;
         endcase
      end

      // divider operands
      unique case (state_in)
         leb_pkg::SEQ_BASE: begin
            div_req.dividend = leb_pkg::DVD_W'(base);
            div_req.divisor  = use_speed ? D_W'(speed_lim) : D_W'(1);
         end
         leb_pkg::SEQ_RECIP1: begin
            div_req.dividend = leb_pkg::RECIP_NUM;
            div_req.divisor  = d1_in;
         end
         leb_pkg::SEQ_RECIP2: begin
            div_req.dividend = leb_pkg::RECIP_NUM;
            div_req.divisor  = d2_ff;
         end
         default: begin
            div_req.dividend = leb_pkg::RECIP_NUM;
            div_req.divisor  = D_W'(1);
         end
      endcase
   end

   assign restart_in = csr_wr && (csr_index == leb_pkg::CSR_PATTERN ||
                                  csr_index == leb_pkg::CSR_SPEED);

   // settings registers and sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         pattern_ff <= leb_pkg::PAT_OFF;
         speed_ff   <= S_W'(1);
         restart_ff <= 1'b1;
         state_ff   <= leb_pkg::SEQ_IDLE;
      end else begin
         restart_ff <= restart_in;
         state_ff   <= state_in;
         if (csr_wr) begin
            unique case (csr_index)
               leb_pkg::CSR_ACTIVE:  active_ff  <= csr_data[0];
               leb_pkg::CSR_PATTERN: pattern_ff <= csr_data[P_W-1:0];
               leb_pkg::CSR_SPEED:   speed_ff   <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // derived constants
   always_ff @(posedge clock) begin
      d1_ff <= d1_in;
      d2_ff <= d2_in;
      if (div_rsp.done && !restart_ff && state_ff == leb_pkg::SEQ_RECIP1) begin
         r1_ff <= div_rsp.quotient;
      end
      if (div_rsp.done && !restart_ff && state_ff == leb_pkg::SEQ_RECIP2) begin
         r2_ff <= div_rsp.quotient;
      end
   end

   assign busy        = restart_ff || (state_ff != leb_pkg::SEQ_IDLE);
   assign cfg.active  = active_ff;
   assign cfg.pattern = pattern_ff;
   assign cfg.d1      = d1_ff;
   assign cfg.r1      = r1_ff;
   assign cfg.d2      = d2_ff;
   assign cfg.r2      = r2_ff;

endmodule

`default_nettype wire

// ----- src/leb_pipe.sv -----
// ----------------------------------------------------------------------------
// leb_pipe
// eight stage brightness datapath: two reciprocal divisions, lcg, rom lookup
// ----------------------------------------------------------------------------
`default_nettype none
`include "led_effect_brightness_core_defines.svh"

module leb_pipe (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic [leb_pkg::T_W-1:0]      in_time_ms,
   input  wire logic                         in_led_select,
   input  wire leb_pkg::cfg_type             cfg,
   output logic                              out_valid,
   output logic [leb_pkg::B_W-1:0]           out_brightness
);

   localparam int T_W = leb_pkg::T_W;
   localparam int R_W = leb_pkg::R_W;
   localparam int D_W = leb_pkg::D_W;
   localparam int X_W = leb_pkg::X_W;
   localparam int Q_W = leb_pkg::Q_W;
   localparam int B_W = leb_pkg::B_W;
   localparam int I_W = leb_pkg::SINE_IDX_W;

   // valid chain
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, out_valid_ff;

   // stage payloads
   logic [T_W-1:0] t1_ff, t2_ff, q0_ff, q0b_ff, qd_ff, q3_ff;
   logic [D_W-1:0] m3_ff;
   logic           led1_ff, led2_ff, led3_ff, led4_ff, led5_ff, led6_ff, led7_ff;
   logic [X_W-1:0] x4_ff, x5_ff, x6_ff, q2_ff, q2b_ff, q2d_ff;
   logic [T_W-1:0] seed4_ff;
   logic [B_W-1:0] dir4_ff, dir5_ff, dir6_ff, dir7_ff;
   logic           fall4_ff, fall5_ff, fall6_ff, fall7_ff;
   logic [B_W-1:0] lcg5_ff, lcg6_ff, lcg7_ff;
   logic [Q_W-1:0] quot7_ff;
   logic [B_W-1:0] out_brightness_ff;

   logic [T_W+R_W-1:0] prod1;
   logic [T_W+D_W-1:0] prod2;
   logic [T_W-1:0]     m0;
   logic               m_ge;
   logic [T_W-1:0]     m_sub;
   logic [D_W-1:0]     m3_in;
   logic [T_W-1:0]     q3_in;
   logic [X_W-1:0]     x4_in;
   logic [T_W-1:0]     seed4_in;
   logic [B_W-1:0]     dir4_in;
   logic               fall4_in;
   logic [D_W-1:0]     m_minus_w;
   logic [X_W+R_W-1:0] prod3;
   logic [T_W-1:0]     lcg_full;
   logic [X_W+D_W-1:0] prod4;
   logic [X_W-1:0]     r0;
   logic               r_ge;
   logic [X_W-1:0]     quot7_full;
   logic [Q_W:0]       idx_sum;
   logic [I_W-1:0]     rom_idx;
   logic [B_W-1:0]     comet_b;
   logic [B_W-1:0]     comet_d;
   logic [B_W-1:0]     pos;
   logic [B_W-1:0]     out_brightness_in;

   // stage 1: quotient estimate t * (2^32 / d1)
   assign prod1 = {{R_W{1'b0}}, in_time_ms} * {{T_W{1'b0}}, cfg.r1};

   // stage 2: back-multiply the estimate
   assign prod2 = {{D_W{1'b0}}, q0_ff} * {{T_W{1'b0}}, cfg.d1};

   // stage 3: remainder with one correction step
   always_comb begin
      m0    = t2_ff - qd_ff;
      m_ge  = m0 >= T_W'(cfg.d1);
      m_sub = m0 - T_W'(cfg.d1);
      m3_in = m_ge ? m_sub[D_W-1:0] : m0[D_W-1:0];
      q3_in = m_ge ? q0b_ff + 1'b1 : q0b_ff;
   end

   // stage 4: pattern front end
   always_comb begin
      x4_in     = '0;
      fall4_in  = 1'b0;
      dir4_in   = '0;
      m_minus_w = m3_ff - cfg.d2;
      seed4_in  = q3_ff + (led3_ff ? leb_pkg::TWINKLE_LED : '0);
      unique case (cfg.pattern)
         leb_pkg::PAT_BREATH, leb_pkg::PAT_WAVE: begin
            x4_in = X_W'(m3_ff) * X_W'(leb_pkg::SINE_ENTRIES);
         end
         leb_pkg::PAT_COMET: begin
            x4_in = X_W'(m3_ff) * X_W'(leb_pkg::BRIGHT_MAX);
         end
         leb_pkg::PAT_PULSE: begin
            if (m3_ff < cfg.d2) begin
               x4_in = X_W'(m3_ff) * X_W'(leb_pkg::BRIGHT_MAX);
            end else if (m3_ff < {cfg.d2[D_W-2:0], 1'b0}) begin
               x4_in    = X_W'(m_minus_w) * X_W'(leb_pkg::BRIGHT_MAX);
               fall4_in = 1'b1;
            end
         end
         leb_pkg::PAT_FAST: begin
            dir4_in = (m3_ff < leb_pkg::FAST_ON) ? leb_pkg::BRIGHT_MAX : '0;
         end
         leb_pkg::PAT_SLOW: begin
            dir4_in = (m3_ff < leb_pkg::SLOW_ON) ? leb_pkg::BRIGHT_MAX : '0;
         end
         leb_pkg::PAT_HEART: begin
            priority if (m3_ff < leb_pkg::HEART_1) dir4_in = leb_pkg::BRIGHT_MAX;
            else if (m3_ff < leb_pkg::HEART_2)     dir4_in = leb_pkg::BRIGHT_DIM;
            else if (m3_ff < leb_pkg::HEART_3)     dir4_in = leb_pkg::BRIGHT_MAX;
            else if (m3_ff < leb_pkg::HEART_4)     dir4_in = leb_pkg::BRIGHT_DIM;
            else                                   dir4_in = '0;
         end
         default: ;
      endcase
   end

   // stage 5: second quotient estimate and lcg
   assign prod3    = {{R_W{1'b0}}, x4_ff} * {{X_W{1'b0}}, cfg.r2};
   assign lcg_full = seed4_ff * leb_pkg::LCG_MUL + leb_pkg::LCG_INC;

   // stage 6: back-multiply
   assign prod4 = {{D_W{1'b0}}, q2_ff} * {{X_W{1'b0}}, cfg.d2};

   // stage 7: correction
   always_comb begin
      r0         = x6_ff - q2d_ff;
      r_ge       = r0 >= X_W'(cfg.d2);
      quot7_full = r_ge ? q2b_ff + 1'b1 : q2b_ff;
   end

   // stage 8: rom lookup and final selection
   always_comb begin
      idx_sum = {1'b0, quot7_ff};
      if (cfg.pattern == leb_pkg::PAT_WAVE && led7_ff) begin
         idx_sum = idx_sum + (Q_W + 1)'(leb_pkg::SINE_ENTRIES / 2);
      end
      if (idx_sum >= (Q_W + 1)'(leb_pkg::SINE_ENTRIES)) begin
         idx_sum = idx_sum - (Q_W + 1)'(leb_pkg::SINE_ENTRIES);
      end
      rom_idx = idx_sum[I_W-1:0];
      pos     = quot7_ff[B_W-1:0];
      comet_d = B_W'((pos - leb_pkg::COMET_TAIL) * leb_pkg::COMET_GAIN);
      if (pos > leb_pkg::COMET_HEAD) begin
         comet_b = leb_pkg::BRIGHT_MAX;
      end else if (pos > leb_pkg::COMET_TAIL) begin
         comet_b = comet_d;
      end else begin
         comet_b = '0;
      end
      if (led7_ff) begin
         comet_b = comet_b >> 1;
      end
      unique case (cfg.pattern)
         leb_pkg::PAT_BREATH, leb_pkg::PAT_WAVE: begin
            out_brightness_in = leb_pkg::SINE_TABLE[rom_idx];
         end
         leb_pkg::PAT_COMET: out_brightness_in = comet_b;
         leb_pkg::PAT_PULSE: begin
            out_brightness_in = fall7_ff ? leb_pkg::BRIGHT_MAX - pos : pos;
         end
         leb_pkg::PAT_TWINKLE: begin
            priority if (lcg7_ff > leb_pkg::TWINKLE_HI) begin
               out_brightness_in = leb_pkg::BRIGHT_MAX;
            end else if (lcg7_ff > leb_pkg::TWINKLE_LO) begin
               out_brightness_in = leb_pkg::BRIGHT_HALF;
            end else begin
               out_brightness_in = '0;
            end
         end
         leb_pkg::PAT_FAST, leb_pkg::PAT_SLOW, leb_pkg::PAT_HEART: begin
            out_brightness_in = dir7_ff;
         end
         default: out_brightness_in = '0;
      endcase
      if (!cfg.active) begin
         out_brightness_in = '0;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         out_valid_ff <= v7_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      t1_ff    <= in_time_ms;
      led1_ff  <= in_led_select;
      q0_ff    <= prod1[T_W +: T_W];

      t2_ff    <= t1_ff;
      led2_ff  <= led1_ff;
      q0b_ff   <= q0_ff;
      qd_ff    <= prod2[T_W-1:0];

      m3_ff    <= m3_in;
      q3_ff    <= q3_in;
      led3_ff  <= led2_ff;

      x4_ff    <= x4_in;
      seed4_ff <= seed4_in;
      dir4_ff  <= dir4_in;
      fall4_ff <= fall4_in;
      led4_ff  <= led3_ff;

      q2_ff    <= prod3[T_W +: X_W];
      x5_ff    <= x4_ff;
      lcg5_ff  <= lcg_full[B_W-1:0];
      dir5_ff  <= dir4_ff;
      fall5_ff <= fall4_ff;
      led5_ff  <= led4_ff;

      q2d_ff   <= prod4[X_W-1:0];
      q2b_ff   <= q2_ff;
      x6_ff    <= x5_ff;
      lcg6_ff  <= lcg5_ff;
      dir6_ff  <= dir5_ff;
      fall6_ff <= fall5_ff;
      led6_ff  <= led5_ff;

      quot7_ff <= quot7_full[Q_W-1:0];
      lcg7_ff  <= lcg6_ff;
      dir7_ff  <= dir6_ff;
      fall7_ff <= fall6_ff;
      led7_ff  <= led6_ff;

      out_brightness_ff <= out_brightness_in;
   end

   assign out_valid      = out_valid_ff;
   assign out_brightness = out_brightness_ff;

   // every item comes out of the output register at the end of the valid chain
   `LEB_ASSERT_IMP(a_latency, in_valid, ##8 out_valid_ff, "item lost in pipeline")
   `LEB_ASSERT_IMP(a_no_ghost, out_valid_ff, $past(in_valid, 8), "result without item")
   `LEB_ASSERT_NXT(a_mid_chain, v3_ff, v4_ff && $past(v1_ff, 3), "valid chain broken")

endmodule

`default_nettype wire

// ----- src/led_effect_brightness_core.sv -----
// items are taken one per cycle while busy is low; each result strobes out of
// the last of the eight register stages of the brightness datapath
// after reset and after each pattern or speed write, busy is high
// while a shared 33-step divider derives period and reciprocals
// the result receiver cannot stall; synchronous active-high reset
// ----------------------------------------------------------------------------
// led_effect_brightness_core
// led animation brightness from a millisecond time stamp and an led select
// ----------------------------------------------------------------------------
`default_nettype none

module led_effect_brightness_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [leb_pkg::T_W-1:0]         req_time_ms,
   input  wire logic                            req_led_select,
   output logic                                 rsp_valid,
   output logic [leb_pkg::B_W-1:0]              rsp_brightness,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [leb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [leb_pkg::S_W-1:0]         csr_data
);

   leb_pkg::cfg_type     cfg;
   leb_pkg::div_req_type div_req;
   leb_pkg::div_rsp_type div_rsp;
   logic                 item_take;

   // item taken when idle
   assign item_take = start && !busy;

   // settings and constant sequencer
   leb_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .busy      (busy),
      .cfg       (cfg),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   // shared iterative divider
   leb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // brightness datapath
   leb_pipe u_pipe (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (item_take),
      .in_time_ms     (req_time_ms),
      .in_led_select  (req_led_select),
      .cfg            (cfg),
      .out_valid      (rsp_valid),
      .out_brightness (rsp_brightness)
   );

endmodule

`default_nettype wire

// ----- dv/led_effect_brightness_core_tb.sv -----
// ----------------------------------------------------------------------------
// led_effect_brightness_core_tb
// Self-checking bench for the brightness core. A directed table walks all
// patterns but slow, the speed clamps and the inactive case; random phases of
// bursty items follow, each entered through register writes while the core is
// idle. Each result is checked against a typed-in value or a brightness model.
// ----------------------------------------------------------------------------
`default_nettype none

module led_effect_brightness_core_tb;

   localparam int T_W          = leb_pkg::T_W;
   localparam int B_W          = leb_pkg::B_W;
   localparam int S_W          = leb_pkg::S_W;
   localparam int P_W          = leb_pkg::P_W;
   localparam int CSR_IDX_W    = leb_pkg::CSR_IDX_W;
   localparam int SINE_ENTRIES = leb_pkg::SINE_ENTRIES;

   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASES      = 38;
   localparam int PHASE_ITEMS = 50;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [T_W-1:0]       req_time_ms = '0;
   logic                 req_led_select = 1'b0;
   logic                 rsp_valid;
   logic [B_W-1:0]       rsp_brightness;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = leb_pkg::CSR_ACTIVE;
   logic [S_W-1:0]       csr_data = '0;

   // typed-in expectation for the item on the ports, -1 means use the model
   int                   drv_want = -1;

   // mirror of the core registers
   logic                 mir_active;
   logic [P_W-1:0]       mir_pattern;
   logic [S_W-1:0]       mir_speed;

   logic [B_W-1:0]       sine_lut [SINE_ENTRIES];
   logic [B_W-1:0]       brightness_due [$];
   int                   errors = 0;
   int                   n_checked = 0;
   int                   n_writes = 0;
   int                   cycles = 0;

   typedef struct {
      bit                   is_cfg;
      logic [CSR_IDX_W-1:0] idx;
      logic [S_W-1:0]       data;
      logic [T_W-1:0]       t;
      bit                   led;
      int                   want;
   } row_type;

   row_type rows [$];

   led_effect_brightness_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_time_ms    (req_time_ms),
      .req_led_select (req_led_select),
      .rsp_valid      (rsp_valid),
      .rsp_brightness (rsp_brightness),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // first quadrant sine in q30, truncated series
   function automatic longint unsigned quad_sin(longint unsigned r, longint unsigned n);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned acc;
      x    = (r * 64'd1686629713 + n / 2) / n;
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      for (int k = 1; k <= 10; k++) begin
         term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
         if (k % 2 == 1) acc = (acc > term) ? acc - term : 0;
         else acc = acc + term;
      end
      return (acc > (64'd1 << 30)) ? (64'd1 << 30) : acc;
   endfunction

   function automatic logic [B_W-1:0] sine_entry(int i);
      longint unsigned n;
      longint unsigned q;
      longint unsigned rem;
      longint unsigned r;
      longint unsigned mag;
      longint unsigned v;
      n   = SINE_ENTRIES;
      q   = (4 * i) / n;
      rem = 4 * i - q * n;
      r   = q[0] ? n - rem : rem;
      if (r == 0) mag = 0;
      else if (r >= n) mag = 64'd1 << 30;
      else mag = quad_sin(r, n);
      v = (q >= 2) ? (64'd1 << 30) - mag : (64'd1 << 30) + mag;
      return B_W'((v * 255) >> 31);
   endfunction

   function automatic logic [B_W-1:0] sine_pattern(logic [T_W-1:0] t, int base, int s,
                                                   int shift);
      longint unsigned p;
      longint unsigned idx;
      p   = base / s;
      idx = ((longint'(t) % p) * SINE_ENTRIES) / p;
      return sine_lut[(idx + shift) % SINE_ENTRIES];
   endfunction

   // brightness for one item under the mirrored registers
   function automatic logic [B_W-1:0] calc_brightness(logic [T_W-1:0] t, logic led);
      int unsigned s;
      int unsigned c;
      int unsigned w;
      int unsigned pos;
      logic [31:0] seed;
      logic [31:0] r;
      logic [B_W-1:0] b;
      s = mir_speed;
      if (s < 1) s = 1;
      if (s > 100) s = 100;
      b = '0;
      if (mir_active) begin
         case (mir_pattern)
            leb_pkg::PAT_BREATH: b = sine_pattern(t, 2000, s, 0);
            leb_pkg::PAT_FAST:   b = ((t % (100 / s)) < 50) ? 8'd255 : 8'd0;
            leb_pkg::PAT_SLOW:   b = ((t % (500 / s)) < 250) ? 8'd255 : 8'd0;
            leb_pkg::PAT_HEART: begin
               c = t % 1000;
               if (c < 100) b = 8'd255;
               else if (c < 200) b = 8'd50;
               else if (c < 300) b = 8'd255;
               else if (c < 400) b = 8'd50;
               else b = 8'd0;
            end
            leb_pkg::PAT_WAVE:   b = sine_pattern(t, 1500, s, led ? SINE_ENTRIES / 2 : 0);
            leb_pkg::PAT_COMET: begin
               c   = 3000 / s;
               pos = (t % c) * 255 / c;
               if (pos > 200) b = 8'd255;
               else if (pos > 150) b = B_W'((pos - 150) * 5);
               else b = 8'd0;
               if (led) b = b >> 1;
            end
            leb_pkg::PAT_PULSE: begin
               w = 200 / s;
               c = t % (w * 4);
               if (c < w) b = B_W'(c * 255 / w);
               else if (c < 2 * w) b = B_W'(255 - (c - w) * 255 / w);
               else b = 8'd0;
            end
            leb_pkg::PAT_TWINKLE: begin
               w    = 200 / s;
               seed = t / w + (led ? 32'd1000 : 32'd0);
               r    = (seed * 32'd1103515245 + 32'd12345) & 32'h7fffffff;
               b    = (r[7:0] > 200) ? 8'd255 : ((r[7:0] > 100) ? 8'd128 : 8'd0);
            end
            default: b = 8'd0;
         endcase
      end
      return b;
   endfunction

   // register mirror, item capture and result check
   always @(posedge clock) begin
      logic [B_W-1:0] due;
      if (reset) begin
         mir_active  <= 1'b0;
         mir_pattern <= leb_pkg::PAT_OFF;
         mir_speed   <= 7'd1;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               leb_pkg::CSR_ACTIVE:  mir_active  <= csr_data[0];
               leb_pkg::CSR_PATTERN: mir_pattern <= csr_data[P_W-1:0];
               leb_pkg::CSR_SPEED:   mir_speed   <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (brightness_due.size() == 0) begin
               $display("%0t: result with nothing due, expected none actual %0d",
                        $time, rsp_brightness);
               errors++;
            end else begin
               due = brightness_due.pop_front();
               n_checked++;
               if (rsp_brightness !== due) begin
                  $display("%0t: brightness mismatch, expected %0d actual %0d",
                           $time, due, rsp_brightness);
                  errors++;
               end
            end
         end
         if (start && !busy)
            brightness_due.push_back(drv_want >= 0 ? B_W'(drv_want)
                                     : calc_brightness(req_time_ms, req_led_select));
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   // hold off until every item has come back, then let the pipe settle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (brightness_due.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [S_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      n_writes++;
   endtask

   // present one item and wait until it is taken
   task automatic send_item(logic [T_W-1:0] t, logic led, int want);
      start          <= 1'b1;
      req_time_ms    <= t;
      req_led_select <= led;
      drv_want       <= want;
      do @(posedge clock); while (!(start && !busy));
   endtask

   function automatic logic [T_W-1:0] rand_time();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(5000);
         2: return 32'hffffffff - $urandom_range(5000);
         default: return $urandom_range(32'h00ffffff);
      endcase
   endfunction

   function automatic logic [S_W-1:0] rand_speed();
      case ($urandom_range(7))
         0: return 7'd0;
         1: return 7'd1;
         2: return 7'd100;
         3: return 7'($urandom_range(127, 101));
         4: return 7'($urandom_range(10, 2));
         default: return 7'($urandom_range(127));
      endcase
   endfunction

   initial begin
      int burst;

      // directed table: typed-in results only where obvious
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'd500,        0, 0});
      rows.push_back('{1, leb_pkg::CSR_ACTIVE,  7'h7f,  0,              0, -1});
      rows.push_back('{1, leb_pkg::CSR_PATTERN, leb_pkg::PAT_HEART, 0,  0, -1});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'd0,          0, 255});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'd150,        1, 50});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'd999,        0, 0});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'hffffffff,   1, -1});
      rows.push_back('{1, leb_pkg::CSR_PATTERN, leb_pkg::PAT_FAST, 0,   0, -1});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'd0,          0, 255});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'd99,         0, 0});
      rows.push_back('{1, leb_pkg::CSR_PATTERN, leb_pkg::PAT_BREATH, 0, 0, -1});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'd0,          0, 127});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'd500,        1, 255});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'd1500,       0, 0});
      rows.push_back('{1, leb_pkg::CSR_PATTERN, leb_pkg::PAT_WAVE, 0,   0, -1});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'd0,          1, 127});
      rows.push_back('{1, leb_pkg::CSR_SPEED,   7'd0,   0,              0, -1});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'd777,        0, -1});
      rows.push_back('{1, leb_pkg::CSR_SPEED,   7'd127, 0,              0, -1});
      rows.push_back('{1, leb_pkg::CSR_PATTERN, leb_pkg::PAT_COMET, 0,  0, -1});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'd29,         1, -1});
      rows.push_back('{1, leb_pkg::CSR_PATTERN, leb_pkg::PAT_PULSE, 0,  0, -1});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'd3,          0, -1});
      rows.push_back('{1, leb_pkg::CSR_PATTERN, leb_pkg::PAT_TWINKLE, 0, 0, -1});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'hfffffffe,   1, -1});
      rows.push_back('{1, leb_pkg::CSR_PATTERN, 7'h7f,  0,              0, -1});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'd123,        0, 0});
      rows.push_back('{1, leb_pkg::CSR_PATTERN, 7'd9,   0,              0, -1});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'd123,        1, 0});
      rows.push_back('{1, leb_pkg::CSR_ACTIVE,  7'h7e,  0,              0, -1});
      rows.push_back('{1, leb_pkg::CSR_PATTERN, leb_pkg::PAT_BREATH, 0, 0, -1});
      rows.push_back('{0, leb_pkg::CSR_ACTIVE,  0,      32'd500,        0, 0});

      for (int i = 0; i < SINE_ENTRIES; i++) sine_lut[i] = sine_entry(i);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].is_cfg) begin
            drain();
            write_reg(rows[i].idx, rows[i].data);
         end else begin
            send_item(rows[i].t, rows[i].led, rows[i].want);
         end
      end

      // random phases, each with fresh settings written while idle
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         write_reg(leb_pkg::CSR_ACTIVE,
                   ($urandom_range(5) == 0) ? 7'($urandom_range(127) & 7'h7e)
                                            : 7'($urandom_range(127) | 7'h01));
         write_reg(leb_pkg::CSR_PATTERN,
                   ($urandom_range(7) == 0) ? 7'($urandom_range(127))
                                            : 7'($urandom_range(leb_pkg::PAT_TWINKLE)));
         write_reg(leb_pkg::CSR_SPEED, rand_speed());
         drv_want <= -1;
         for (int n = 0; n < PHASE_ITEMS; ) begin
            burst = (ph % 5 == 0) ? PHASE_ITEMS : $urandom_range(12, 1);
            for (int k = 0; k < burst && n < PHASE_ITEMS; k++, n++)
               send_item(rand_time(), $urandom_range(1), -1);
            if ($urandom_range(2) != 0) begin
               start <= 1'b0;
               repeat ($urandom_range(6, 1)) @(posedge clock);
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("checked %0d brightness items across %0d register writes",
               n_checked, n_writes);
      $display("all nine patterns, unknown codes, speed clamps and inactive mode covered");
      if (errors == 0 && brightness_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
